@@ rtl/swhsr_pkg.sv @@
// ----------------------------------------------------------------------------
// swhsr_pkg: shared types and constants
// Command, phase and status codes, the register file layout and the word
// types passed between the front end, the queue and the back end.
// ----------------------------------------------------------------------------
package swhsr_pkg;

  localparam int unsigned NUM_BITS  = 40;
  localparam int unsigned CFG_AW    = 4;
  localparam int unsigned CFG_DW    = 32;

  // command codes on the input channel
  localparam logic [1:0] CMD_TICK   = 2'd0;
  localparam logic [1:0] CMD_START  = 2'd1;
  localparam logic [1:0] CMD_FINISH = 2'd2;

  // register indexes
  localparam logic [1:0] REG_RESP_TO  = 2'd0;
  localparam logic [1:0] REG_LOW_TO   = 2'd1;
  localparam logic [1:0] REG_HIGH_TO  = 2'd2;
  localparam logic [1:0] REG_ONE_THR  = 2'd3;

  // register reset values
  localparam logic [7:0] RESP_TO_RST  = 8'd100;
  localparam logic [7:0] LOW_TO_RST   = 8'd80;
  localparam logic [7:0] HIGH_TO_RST  = 8'd120;
  localparam logic [7:0] ONE_THR_RST  = 8'd45;

  localparam logic [7:0] WAIT_MAX     = 8'd255;
  localparam logic [5:0] LAST_BIT     = 6'(NUM_BITS - 1);

  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_TIMEOUT  = 2'd1;
  localparam logic [1:0] STATUS_CHECKSUM = 2'd2;

  localparam logic [2:0] STEP_NONE     = 3'd0;
  localparam logic [2:0] STEP_CHECKSUM = 3'd6;

  typedef enum logic [1:0] {
    OP_TICK,
    OP_START,
    OP_FINISH,
    OP_NOP
  } op_t;

  // phase codes double as the failing step of a timeout
  typedef enum logic [2:0] {
    PH_IDLE      = 3'd0,
    PH_RESP_LOW1 = 3'd1,
    PH_RESP_HIGH = 3'd2,
    PH_RESP_LOW2 = 3'd3,
    PH_BIT_RISE  = 3'd4,
    PH_BIT_FALL  = 3'd5
  } phase_t;

  typedef struct packed {
    op_t  op;
    logic line;
  } item_t;

  typedef struct packed {
    logic [7:0] resp_to;
    logic [7:0] low_to;
    logic [7:0] high_to;
    logic [7:0] one_thr;
  } cfg_t;

  typedef struct packed {
    logic        drive_low;
    logic        busy;
    logic        done;
    logic [1:0]  status;
    logic [2:0]  fail_step;
    logic [31:0] reading;
  } result_t;

endpackage

@@ rtl/swhsr_if.sv @@
// ----------------------------------------------------------------------------
// swhsr channel interfaces
// Valid/ready channels for command words and result words.
// ----------------------------------------------------------------------------
interface swhsr_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] cmd;
  logic       line_level;

  modport source (output valid, output cmd, output line_level, input ready);
  modport sink   (input valid, input cmd, input line_level, output ready);
endinterface

interface swhsr_out_if;
  logic       valid;
  logic       ready;
  logic       drive_low;
  logic       busy_res;
  logic       done_res;
  logic [1:0] status;
  logic [2:0] fail_step;
  logic [7:0] humidity_whole;
  logic [7:0] humidity_tenths;
  logic [7:0] temperature_whole;
  logic [7:0] temperature_tenths;

  modport source (
    output valid, output drive_low, output busy_res, output done_res,
    output status, output fail_step, output humidity_whole,
    output humidity_tenths, output temperature_whole,
    output temperature_tenths, input ready
  );
  modport sink (
    input valid, input drive_low, input busy_res, input done_res,
    input status, input fail_step, input humidity_whole,
    input humidity_tenths, input temperature_whole,
    input temperature_tenths, output ready
  );
endinterface

@@ rtl/swhsr_front.sv @@
// ----------------------------------------------------------------------------
// swhsr_front: command intake
// Registers each accepted command word and decodes it into an operation.
// ----------------------------------------------------------------------------
module swhsr_front (
  input  logic                 clk,
  input  logic                 rst,
  swhsr_in_if.sink             in_ch,
  output logic                 item_valid,
  input  logic                 item_ready,
  output swhsr_pkg::item_t     item
);

  swhsr_pkg::op_t op_dec;

  always_comb begin
    case (in_ch.cmd)
      swhsr_pkg::CMD_TICK:   op_dec = swhsr_pkg::OP_TICK;
      swhsr_pkg::CMD_START:  op_dec = swhsr_pkg::OP_START;
      swhsr_pkg::CMD_FINISH: op_dec = swhsr_pkg::OP_FINISH;
      default:               op_dec = swhsr_pkg::OP_NOP;
    endcase
  end

  assign in_ch.ready = !item_valid || item_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_ch.ready) begin
      item_valid <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      item.op   <= op_dec;
      item.line <= in_ch.line_level;
    end
  end

endmodule

@@ rtl/swhsr_queue.sv @@
// ----------------------------------------------------------------------------
// swhsr_queue: two-entry word queue
// Decouples the intake from the sequencer so either side can stall.
// ----------------------------------------------------------------------------
module swhsr_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  swhsr_pkg::item_t in_item,
  output logic             out_valid,
  input  logic             out_ready,
  output swhsr_pkg::item_t out_item
);

  swhsr_pkg::item_t mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  logic       pop;

  assign in_ready  = (count != 2'd2);
  assign out_valid = (count != 2'd0);
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;
  assign out_item  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop)  rd_ptr <= !rd_ptr;
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= in_item;
  end

endmodule

@@ rtl/swhsr_back.sv @@
// ----------------------------------------------------------------------------
// swhsr_back: reception sequencer
// Runs the response and bit timing state machine one word per cycle, unless a
// stalled out_ch holds the result word, and registers the result word for the output channel.
// ----------------------------------------------------------------------------
module swhsr_back (
  input  logic             clk,
  input  logic             rst,
  input  swhsr_pkg::cfg_t  cfg,
  input  logic             item_valid,
  output logic             item_ready,
  input  swhsr_pkg::item_t item,
  swhsr_out_if.source      out_ch
);

  swhsr_pkg::phase_t phase, phase_next;
  logic [7:0]  wait_count, wait_count_next;
  logic [5:0]  bit_index, bit_index_next;
  logic [39:0] shift_bits, shift_bits_next;
  logic [2:0]  fail_step, fail_step_next;
  logic        drive_low, drive_low_next;
  logic [31:0] reading, reading_next;
  logic [1:0]  status, status_next;
  logic        done_next;

  logic        want;
  logic [7:0]  limit;
  logic        match;
  logic        timed_out;
  logic        bit_val;
  logic [39:0] shifted;
  logic [7:0]  sum;

  swhsr_pkg::result_t res;
  logic               res_valid;
  logic               take;

  assign item_ready = !res_valid || out_ch.ready;
  assign take       = item_valid && item_ready;

  always_comb begin
    case (phase)
      swhsr_pkg::PH_RESP_HIGH: begin
        want  = 1'b1;
        limit = cfg.resp_to;
      end
      swhsr_pkg::PH_BIT_RISE: begin
        want  = 1'b1;
        limit = cfg.low_to;
      end
      swhsr_pkg::PH_BIT_FALL: begin
        want  = 1'b0;
        limit = cfg.high_to;
      end
      default: begin
        want  = 1'b0;
        limit = cfg.resp_to;
      end
    endcase
  end

  assign match     = (item.line == want);
  assign timed_out = !match && (wait_count >= limit);
  // pulse width is wait_count + 1, so width > threshold means wait_count >= threshold
  assign bit_val   = (wait_count >= cfg.one_thr);
  assign shifted   = {shift_bits[38:0], bit_val};
  assign sum       = shifted[39:32] + shifted[31:24] + shifted[23:16] + shifted[15:8];

  always_comb begin
    phase_next      = phase;
    wait_count_next = wait_count;
    bit_index_next  = bit_index;
    shift_bits_next = shift_bits;
    fail_step_next  = fail_step;
    drive_low_next  = drive_low;
    reading_next    = reading;
    status_next     = status;
    done_next       = 1'b0;
    case (item.op)
      swhsr_pkg::OP_START: begin
        fail_step_next  = swhsr_pkg::STEP_NONE;
        drive_low_next  = 1'b1;
        phase_next      = swhsr_pkg::PH_IDLE;
        wait_count_next = 8'd0;
      end
      swhsr_pkg::OP_FINISH: begin
        drive_low_next  = 1'b0;
        phase_next      = swhsr_pkg::PH_RESP_LOW1;
        wait_count_next = 8'd0;
        bit_index_next  = 6'd0;
        shift_bits_next = 40'd0;
      end
      swhsr_pkg::OP_TICK: begin
        if (phase != swhsr_pkg::PH_IDLE) begin
          if (match) begin
            wait_count_next = 8'd0;
            case (phase)
              swhsr_pkg::PH_RESP_LOW1: phase_next = swhsr_pkg::PH_RESP_HIGH;
              swhsr_pkg::PH_RESP_HIGH: phase_next = swhsr_pkg::PH_RESP_LOW2;
              swhsr_pkg::PH_RESP_LOW2: phase_next = swhsr_pkg::PH_BIT_RISE;
              swhsr_pkg::PH_BIT_RISE:  phase_next = swhsr_pkg::PH_BIT_FALL;
              swhsr_pkg::PH_BIT_FALL: begin
                shift_bits_next = shifted;
                bit_index_next  = bit_index + 6'd1;
                if (bit_index == swhsr_pkg::LAST_BIT) begin
                  phase_next = swhsr_pkg::PH_IDLE;
                  done_next  = 1'b1;
                  if (sum == shifted[7:0]) begin
                    reading_next   = shifted[39:8];
                    status_next    = swhsr_pkg::STATUS_OK;
                    fail_step_next = swhsr_pkg::STEP_NONE;
                  end else begin
                    status_next    = swhsr_pkg::STATUS_CHECKSUM;
                    fail_step_next = swhsr_pkg::STEP_CHECKSUM;
                  end
                end else begin
                  phase_next = swhsr_pkg::PH_BIT_RISE;
                end
              end
              default: phase_next = swhsr_pkg::PH_IDLE;
            endcase
          end else if (timed_out) begin
            // the phase code is the failing step
            phase_next      = swhsr_pkg::PH_IDLE;
            wait_count_next = 8'd0;
            status_next     = swhsr_pkg::STATUS_TIMEOUT;
            fail_step_next  = 3'(phase);
            done_next       = 1'b1;
          end else if (wait_count != swhsr_pkg::WAIT_MAX) begin
            wait_count_next = wait_count + 8'd1;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= swhsr_pkg::PH_IDLE;
      wait_count <= 8'd0;
      bit_index  <= 6'd0;
      shift_bits <= 40'd0;
      fail_step  <= swhsr_pkg::STEP_NONE;
      drive_low  <= 1'b0;
      reading    <= 32'd0;
      status     <= swhsr_pkg::STATUS_OK;
    end else if (take) begin
      phase      <= phase_next;
      wait_count <= wait_count_next;
      bit_index  <= bit_index_next;
      shift_bits <= shift_bits_next;
      fail_step  <= fail_step_next;
      drive_low  <= drive_low_next;
      reading    <= reading_next;
      status     <= status_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (item_ready) begin
      res_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      res.drive_low <= drive_low_next;
      res.busy      <= (phase_next != swhsr_pkg::PH_IDLE);
      res.done      <= done_next;
      res.status    <= status_next;
      res.fail_step <= fail_step_next;
      res.reading   <= reading_next;
    end
  end

  assign out_ch.valid              = res_valid;
  assign out_ch.drive_low          = res.drive_low;
  assign out_ch.busy_res           = res.busy;
  assign out_ch.done_res           = res.done;
  assign out_ch.status             = res.status;
  assign out_ch.fail_step          = res.fail_step;
  assign out_ch.humidity_whole     = res.reading[31:24];
  assign out_ch.humidity_tenths    = res.reading[23:16];
  assign out_ch.temperature_whole  = res.reading[15:8];
  assign out_ch.temperature_tenths = res.reading[7:0];

endmodule

@@ rtl/single_wire_humidity_sensor_reader.sv @@
// ----------------------------------------------------------------------------
// single_wire_humidity_sensor_reader: single-wire sensor reception engine
// Takes start, finish and sampled-line tick words, times the sensor's
// response and 40 data pulses, checks the byte sum and reports one result
// word per command word.
//
//   channel  dir  handshake       word
//   in_ch    in   valid/ready     cmd, line_level
//   out_ch   out  valid/ready     drive_low .. temperature_tenths
//   apb      in   psel/penable    four 8-bit timing registers at 4*i
//
// One word per cycle sustained while out_ch is ready; each taken command word
// passes the intake register, the queue and the sequencer output register.
// The sequencer's compare, count and shift step sets the rate.
// rst is synchronous; it resets the sequencer, queue, valid flags and timing registers.
// A stalled out_ch holds the result register; the queue and intake register
// absorb up to three more words before in_ch.ready drops.
// ----------------------------------------------------------------------------
module single_wire_humidity_sensor_reader (
  input  logic                             clk,
  input  logic                             rst,
  swhsr_in_if.sink                         in_ch,
  swhsr_out_if.source                      out_ch,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [swhsr_pkg::CFG_AW-1:0]     paddr,
  input  logic [swhsr_pkg::CFG_DW-1:0]     pwdata,
  output logic [swhsr_pkg::CFG_DW-1:0]     prdata,
  output logic                             pready
);

  swhsr_pkg::cfg_t  cfg;
  swhsr_pkg::item_t f_item;
  swhsr_pkg::item_t q_item;
  logic             f_valid;
  logic             f_ready;
  logic             q_valid;
  logic             q_ready;
  logic [1:0]       reg_sel;
  logic             cfg_wr;
  logic [7:0]       rd_byte;

  assign pready  = 1'b1;
  assign reg_sel = paddr[3:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.resp_to <= swhsr_pkg::RESP_TO_RST;
      cfg.low_to  <= swhsr_pkg::LOW_TO_RST;
      cfg.high_to <= swhsr_pkg::HIGH_TO_RST;
      cfg.one_thr <= swhsr_pkg::ONE_THR_RST;
    end else if (cfg_wr) begin
      case (reg_sel)
        swhsr_pkg::REG_RESP_TO: cfg.resp_to <= pwdata[7:0];
        swhsr_pkg::REG_LOW_TO:  cfg.low_to  <= pwdata[7:0];
        swhsr_pkg::REG_HIGH_TO: cfg.high_to <= pwdata[7:0];
        swhsr_pkg::REG_ONE_THR: cfg.one_thr <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      swhsr_pkg::REG_RESP_TO: rd_byte = cfg.resp_to;
      swhsr_pkg::REG_LOW_TO:  rd_byte = cfg.low_to;
      swhsr_pkg::REG_HIGH_TO: rd_byte = cfg.high_to;
      swhsr_pkg::REG_ONE_THR: rd_byte = cfg.one_thr;
      default:                rd_byte = 8'd0;
    endcase
  end

  assign prdata = {{(swhsr_pkg::CFG_DW - 8){1'b0}}, rd_byte};

  swhsr_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_ch      (in_ch),
    .item_valid (f_valid),
    .item_ready (f_ready),
    .item       (f_item)
  );

  swhsr_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (f_valid),
    .in_ready  (f_ready),
    .in_item   (f_item),
    .out_valid (q_valid),
    .out_ready (q_ready),
    .out_item  (q_item)
  );

  swhsr_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .item_valid (q_valid),
    .item_ready (q_ready),
    .item       (q_item),
    .out_ch     (out_ch)
  );

endmodule
